### src/tfb_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// telemetry frame builder. No dependencies.
package tfb_pkg;

   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;
   localparam logic [15:0] CrcTop  = 16'h8000;

   // Control/status register file
   localparam int unsigned CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CsrSyncFirst  = CsrIndexW'(0);
   localparam logic [CsrIndexW-1:0] CsrSyncSecond = CsrIndexW'(1);
   localparam logic [7:0] SyncFirstReset  = 8'hAA;
   localparam logic [7:0] SyncSecondReset = 8'hAF;

   // Default depth of the command queue between front and back
   localparam int unsigned QueueDepthDefault = 4;

   // Byte emission steps of the back end; ST_NEXT means the head command
   // has not started yet
   typedef enum logic [2:0] {
      ST_NEXT,
      ST_SYNC_A,
      ST_SYNC_B,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_CRC_LO,
      ST_CRC_HI
   } step_type;

   // One classified input item, as handed from front to back
   typedef struct packed {
      logic       start;
      logic       has_data;
      logic       finish;
      logic [7:0] sync_a;
      logic [7:0] sync_b;
      logic [7:0] frame_id;
      logic [7:0] payload_len;
      logic [7:0] data_byte;
   } cmd_type;

   // Advance the CRC by one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CrcTop) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### src/telemetry_frame_builder_crc16.sv
// Top level of the telemetry frame builder with CRC-16/CCITT-FALSE.
// Joins front end, command queue and back end. Depends on tfb_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  req_     | in        | req_valid/stall    | frame_id, payload_len, data_byte
//  rsp_     | out       | rsp_valid/stall    | out_byte, run_last, frame_last
//  csr_     | in        | csr_valid/ready    | index (0 sync_first, 1 sync_second)
//
// The output emits one byte per cycle unless rsp_stall holds it; that port
// sets the rate. Input is taken every cycle while the command queue has
// room; each item passes through a queue entry and then the output register.
// Reset is synchronous and clears the control state and valid flags; queue
// entries and output payload are not reset, and no clearing pass is needed.
// Either side may stall independently; the queue absorbs the difference.
module telemetry_frame_builder_crc16
   import tfb_pkg::*;
#(
   parameter int unsigned QueueDepth = QueueDepthDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_frame_id,
   input  logic [7:0]           req_payload_len,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   tfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_id    (req_frame_id),
      .req_payload_len (req_payload_len),
      .req_data_byte   (req_data_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .queue_full      (queue_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   tfb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

### src/tfb_front.sv
// Front end of the frame builder: sync registers, frame tracking and
// classification of each input byte into a command. Depends on tfb_pkg.
module tfb_front
   import tfb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_frame_id,
   input  logic [7:0]           req_payload_len,
   input  logic [7:0]           req_data_byte,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 queue_full,
   output logic                 push,
   output cmd_type              push_cmd
);

   logic [7:0] sync_first_ff,  sync_first_in;
   logic [7:0] sync_second_ff, sync_second_in;
   logic       in_frame_ff,    in_frame_in;
   logic [7:0] bytes_left_ff,  bytes_left_in;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid) begin
         if (csr_index == CsrSyncFirst) begin
            sync_first_in = csr_wdata;
         end else if (csr_index == CsrSyncSecond) begin
            sync_second_in = csr_wdata;
         end
      end
   end

   // Hold off input while the queue is full
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the byte and advance frame tracking
   always_comb begin
      push_cmd.start       = !in_frame_ff;
      push_cmd.sync_a      = sync_first_ff;
      push_cmd.sync_b      = sync_second_ff;
      push_cmd.frame_id    = req_frame_id;
      push_cmd.payload_len = req_payload_len;
      push_cmd.data_byte   = req_data_byte;
      push_cmd.has_data    = 1'b1;
      push_cmd.finish      = 1'b0;
      in_frame_in          = in_frame_ff;
      bytes_left_in        = bytes_left_ff;
      if (!in_frame_ff) begin
         if (req_payload_len == 8'd0) begin
            // empty frame: header then CRC, data byte dropped
            push_cmd.has_data = 1'b0;
            push_cmd.finish   = 1'b1;
            bytes_left_in     = 8'd0;
         end else begin
            push_cmd.finish = (req_payload_len == 8'd1);
            bytes_left_in   = req_payload_len - 8'd1;
            in_frame_in     = (req_payload_len != 8'd1);
         end
      end else begin
         push_cmd.finish = (bytes_left_ff == 8'd1);
         bytes_left_in   = bytes_left_ff - 8'd1;
         in_frame_in     = (bytes_left_ff != 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SyncFirstReset;
         sync_second_ff <= SyncSecondReset;
         in_frame_ff    <= 1'b0;
         bytes_left_ff  <= 8'd0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         if (push) begin
            in_frame_ff   <= in_frame_in;
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

endmodule

### src/tfb_queue.sv
// Short command queue between front and back ends of the frame builder.
// Depends on tfb_pkg for the command type.
module tfb_queue
   import tfb_pkg::*;
#(
   parameter int unsigned Depth = QueueDepthDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   cmd_type             entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff,  count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command at the write pointer
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("queue count did not grow on push");
`endif

endmodule

### src/tfb_back.sv
// Back end of the frame builder: steps through each queued command one
// output byte per cycle while the output is not stalled, keeps the running
// CRC and drives the output register. Depends on tfb_pkg.
module tfb_back
   import tfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_last
);

   step_type    state_ff, state_in;
   step_type    cur_step, step_after;
   logic [15:0] crc_ff, crc_in, crc_base;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        run_last_ff, run_last_in;
   logic        frame_last_ff, frame_last_in;
   logic        out_load;
   logic        emit;
   logic        last_step;

   // Output register takes a new byte when empty or being drained
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign emit     = head_valid && out_load;

   // Step of the head command that goes out now
   always_comb begin
      if (state_ff == ST_NEXT) begin
         cur_step = head_cmd.start ? ST_SYNC_A : ST_DATA;
      end else begin
         cur_step = state_ff;
      end
   end

   always_comb begin
      case (cur_step)
         ST_SYNC_A: step_after = ST_SYNC_B;
         ST_SYNC_B: step_after = ST_ID;
         ST_ID:     step_after = ST_LEN;
         ST_LEN:    step_after = head_cmd.has_data ? ST_DATA : ST_CRC_LO;
         ST_DATA:   step_after = head_cmd.finish ? ST_CRC_LO : ST_NEXT;
         ST_CRC_LO: step_after = ST_CRC_HI;
         ST_CRC_HI: step_after = ST_NEXT;
         default:   step_after = ST_NEXT;
      endcase
   end

   assign last_step = (step_after == ST_NEXT);

   // Next state
   always_comb begin
      state_in = emit ? step_after : state_ff;
   end

   // Outputs of the sequencer: byte, flags, CRC and pop
   always_comb begin
      crc_base = (cur_step == ST_SYNC_A) ? CrcInit : crc_ff;
      case (cur_step)
         ST_SYNC_A: out_byte_in = head_cmd.sync_a;
         ST_SYNC_B: out_byte_in = head_cmd.sync_b;
         ST_ID:     out_byte_in = head_cmd.frame_id;
         ST_LEN:    out_byte_in = head_cmd.payload_len;
         ST_DATA:   out_byte_in = head_cmd.data_byte;
         ST_CRC_LO: out_byte_in = crc_ff[7:0];
         ST_CRC_HI: out_byte_in = crc_ff[15:8];
         default:   out_byte_in = head_cmd.data_byte;
      endcase
      case (cur_step)
         ST_CRC_LO: crc_in = crc_ff;
         ST_CRC_HI: crc_in = CrcInit;
         default:   crc_in = crc_byte(crc_base, out_byte_in);
      endcase
      run_last_in   = last_step;
      frame_last_in = (cur_step == ST_CRC_HI);
      pop           = emit && last_step;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_NEXT;
         crc_ff       <= CrcInit;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            crc_ff <= crc_in;
         end
      end
   end

   // Payload of the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff   <= out_byte_in;
         run_last_ff   <= run_last_in;
         frame_last_ff <= frame_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_last = frame_last_ff;

`ifndef SYNTHESIS
   a_frame_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_last_ff |-> run_last_ff)
      else $error("frame end without run end");
   a_crc_reinit: assert property (@(posedge clock) disable iff (reset)
      emit && cur_step == ST_CRC_HI |=> crc_ff == CrcInit)
      else $error("CRC not reinitialised after frame end");
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_NEXT |-> head_valid)
      else $error("command left the queue before its last byte");
`endif

endmodule
